// ===== hdl/acwr_pkg.sv =====
// Shared types and constants for the age-counter way replacement block.
// No dependencies; every other file imports this package.
package acwr_pkg;

   localparam int FUNC_BITS = 2;
   localparam int WAY_BITS  = 3;
   localparam int CFG_BITS  = 4;
   localparam int OUT_WAYS  = 8;

   // Request function codes
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_USE    = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_BOTH   = 2'd3;

   localparam logic [CFG_BITS-1:0] WAYS_IN_USE_RESET = 4'd8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Controls for one way's age step
   typedef struct packed {
      logic upd_insert;
      logic upd_use;
      logic clear;
   } step_ctl_type;

endpackage

// ===== hdl/acwr_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on acwr_pkg for field widths.
interface acwr_req_if import acwr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [WAY_BITS-1:0]  way;

   modport source (output valid, output func, output way, input ready);
   modport sink   (input valid, input func, input way, output ready);
endinterface

interface acwr_rsp_if import acwr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WAY_BITS-1:0] fifo_victim;
   logic [WAY_BITS-1:0] lru_victim;

   modport source (output valid, output fifo_victim, output lru_victim, input ready);
   modport sink   (input valid, input fifo_victim, input lru_victim, output ready);
endinterface

// ===== hdl/acwr_age_step.sv =====
// Shared age step: clears or saturating-increments one way's two ages.
// Depends on acwr_pkg for step_ctl_type.
module acwr_age_step import acwr_pkg::*; #(
   parameter int AGE_BITS = 8
) (
   input  logic [AGE_BITS-1:0] insert_age,
   input  logic [AGE_BITS-1:0] use_age,
   input  step_ctl_type        ctl,
   output logic [AGE_BITS-1:0] insert_age_next,
   output logic [AGE_BITS-1:0] use_age_next
);

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   function automatic logic [AGE_BITS-1:0] step_age(
      input logic [AGE_BITS-1:0] age,
      input logic                upd,
      input logic                clr
   );
      logic [AGE_BITS-1:0] res;
      res = age;
      if (upd) begin
         if (clr) begin
            res = '0;
         end else if (age != AGE_MAX) begin
            res = age + AGE_BITS'(1);
         end
      end
      return res;
   endfunction

   assign insert_age_next = step_age(insert_age, ctl.upd_insert, ctl.clear);
   assign use_age_next    = step_age(use_age, ctl.upd_use, ctl.clear);

endmodule

// ===== hdl/age_counter_way_replacement.sv =====
// Age-counter replacement for one cache set: per-way insertion age (FIFO) and use age (LRU).
// A request beat is accepted in ST_IDLE; ST_RUN then visits n ways in turn, where n is ways_in_use
// clamped to 1..min(WAYS, 8), and for each way the single shared age step updates that
// way and feeds the FIFO match and LRU maximum compare. The response beat is registered, so a
// new request is accepted while the last response still waits; a run only finishes once the
// response register is free.
// Depends on acwr_pkg, acwr_req_if/acwr_rsp_if and acwr_age_step.
module age_counter_way_replacement import acwr_pkg::*; #(
   parameter int WAYS     = 8,
   parameter int AGE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   acwr_req_if.sink            req_chan,
   acwr_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data
);

   localparam int LIM = (WAYS < OUT_WAYS) ? WAYS : OUT_WAYS;
   localparam int IW  = (LIM > 1) ? $clog2(LIM) : 1;
   localparam int CW  = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;
   localparam logic [CFG_BITS-1:0] LIM_N = CFG_BITS'(LIM);

   state_type             state_ff, state_in;
   logic [CFG_BITS-1:0]   ways_ff;
   logic [CFG_BITS-1:0]   n_ff, n_in;
   logic [WAY_BITS-1:0]   way_ff;
   logic                  upd_ins_ff, upd_use_ff;
   logic                  upd_ins_in, upd_use_in;
   logic [IW-1:0]         idx_ff;
   logic                  found_ff, found_in;
   logic [WAY_BITS-1:0]   fifo_ff, fifo_in;
   logic [WAY_BITS-1:0]   lru_ff, lru_in;
   logic [AGE_BITS-1:0]   best_ff, best_in;
   logic                  rsp_valid_ff;
   logic [WAY_BITS-1:0]   rsp_fifo_ff, rsp_lru_ff;
   logic [AGE_BITS-1:0]   ins_age_ff [LIM];
   logic [AGE_BITS-1:0]   use_age_ff [LIM];

   logic                  accept, step_go, load, last, out_free, fifo_hit, lru_take;
   logic [CFG_BITS-1:0]   n_minus1;
   logic [AGE_BITS-1:0]   ins_new, use_new;
   step_ctl_type          ctl;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign n_minus1 = n_ff - CFG_BITS'(1);
   assign last     = (CFG_BITS'(idx_ff) == n_minus1);

   // clamp the way count and qualify the update at accept
   always_comb begin
      if (ways_ff == '0) begin
         n_in = CFG_BITS'(1);
      end else if (ways_ff > LIM_N) begin
         n_in = LIM_N;
      end else begin
         n_in = ways_ff;
      end
      unique case (req_chan.func)
         FUNC_QUERY:  begin upd_ins_in = 1'b0; upd_use_in = 1'b0; end
         FUNC_INSERT: begin upd_ins_in = 1'b1; upd_use_in = 1'b0; end
         FUNC_USE:    begin upd_ins_in = 1'b0; upd_use_in = 1'b1; end
         FUNC_BOTH:   begin upd_ins_in = 1'b1; upd_use_in = 1'b1; end
         default:     begin upd_ins_in = 1'b0; upd_use_in = 1'b0; end
      endcase
      if (CFG_BITS'(req_chan.way) >= n_in) begin
         upd_ins_in = 1'b0;
         upd_use_in = 1'b0;
      end
   end

   assign ctl.upd_insert = upd_ins_ff;
   assign ctl.upd_use    = upd_use_ff;
   assign ctl.clear      = (WAY_BITS'(idx_ff) == way_ff);

   acwr_age_step #(.AGE_BITS(AGE_BITS)) u_step (
      .insert_age      (ins_age_ff[idx_ff]),
      .use_age         (use_age_ff[idx_ff]),
      .ctl             (ctl),
      .insert_age_next (ins_new),
      .use_age_next    (use_new)
   );

   assign fifo_hit = !found_ff && (CW'(ins_new) == CW'(n_minus1));
   assign lru_take = (idx_ff == '0) || (use_new > best_ff);
   assign found_in = found_ff || fifo_hit;
   assign fifo_in  = fifo_hit ? WAY_BITS'(idx_ff) : fifo_ff;
   assign lru_in   = lru_take ? WAY_BITS'(idx_ff) : lru_ff;
   assign best_in  = lru_take ? use_new : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      accept         = 1'b0;
      step_go        = 1'b0;
      load           = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            accept         = req_chan.valid;
            if (req_chan.valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // hold on the last way until the response register frees up
            step_go = !last || out_free;
            load    = last && out_free;
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= WAYS_IN_USE_RESET;
      end else if (csr_wr_en) begin
         ways_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff       <= n_in;
         way_ff     <= req_chan.way;
         upd_ins_ff <= upd_ins_in;
         upd_use_ff <= upd_use_in;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         fifo_ff    <= '0;
         lru_ff     <= '0;
         best_ff    <= '0;
      end else if (step_go) begin
         idx_ff   <= idx_ff + IW'(1);
         found_ff <= found_in;
         fifo_ff  <= fifo_in;
         lru_ff   <= lru_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIM; i++) begin
            ins_age_ff[i] <= '0;
            use_age_ff[i] <= '0;
         end
      end else if (step_go) begin
         ins_age_ff[idx_ff] <= ins_new;
         use_age_ff[idx_ff] <= use_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_fifo_ff <= fifo_in;
         rsp_lru_ff  <= lru_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fifo_victim = rsp_fifo_ff;
   assign rsp_chan.lru_victim  = rsp_lru_ff;

endmodule

// ===== dv/tb_age_counter_way_replacement.sv =====
// Testbench for age_counter_way_replacement: sends request beats, predicts both victims of
// every beat from its own copy of the age counters and checks response beats in order.
// Depends on acwr_pkg, acwr_req_if/acwr_rsp_if and the block under test.
module tb_age_counter_way_replacement;
   import acwr_pkg::*;

   localparam int WAYS     = 8;
   localparam int AGE_BITS = 8;
   localparam logic [AGE_BITS-1:0] AGE_TOP = '1;
   localparam int MAX_REPORTS = 50;

   typedef struct packed {
      logic [WAY_BITS-1:0] fifo_victim;
      logic [WAY_BITS-1:0] lru_victim;
   } victim_pair_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CFG_BITS-1:0] csr_wr_data;

   acwr_req_if req_if ();
   acwr_rsp_if rsp_if ();

   age_counter_way_replacement #(
      .WAYS     (WAYS),
      .AGE_BITS (AGE_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the set
   logic [AGE_BITS-1:0] insert_age_q [WAYS];
   logic [AGE_BITS-1:0] use_age_q [WAYS];
   logic [CFG_BITS-1:0] ways_setting;
   victim_pair_type     victims_pending [$];

   int errors;
   int beats_sent;
   int beats_checked;
   int csr_writes;
   bit gaps_on;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int live_ways();
      int lim;
      int n;
      lim = (WAYS < OUT_WAYS) ? WAYS : OUT_WAYS;
      n = int'(ways_setting);
      if (n < 1) n = 1;
      if (n > lim) n = lim;
      return n;
   endfunction

   function automatic logic [AGE_BITS-1:0] aged(logic [AGE_BITS-1:0] age);
      return (age == AGE_TOP) ? AGE_TOP : age + AGE_BITS'(1);
   endfunction

   // Apply one beat to the shadow ages and return the victims it must report.
   function automatic victim_pair_type predict_victims(logic [FUNC_BITS-1:0] f,
                                                       logic [WAY_BITS-1:0] w);
      int n;
      bit found;
      logic [AGE_BITS-1:0] best;
      victim_pair_type v;
      n = live_ways();
      found = 1'b0;
      best = '0;
      v = '0;
      if (int'(w) < n) begin
         for (int i = 0; i < n; i++) begin
            if (f == FUNC_INSERT || f == FUNC_BOTH)
               insert_age_q[i] = (i == int'(w)) ? '0 : aged(insert_age_q[i]);
            if (f == FUNC_USE || f == FUNC_BOTH)
               use_age_q[i] = (i == int'(w)) ? '0 : aged(use_age_q[i]);
         end
      end
      for (int i = 0; i < n; i++) begin
         if (!found && int'(insert_age_q[i]) == n - 1) begin
            v.fifo_victim = WAY_BITS'(i);
            found = 1'b1;
         end
         if (i == 0 || use_age_q[i] > best) begin
            best = use_age_q[i];
            v.lru_victim = WAY_BITS'(i);
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] expected,
                                  input logic [7:0] got);
      if (errors < MAX_REPORTS)
         $display("mismatch at response beat %0d: %s expected %0d got %0d",
                  beats_checked, what, expected, got);
      errors++;
   endtask

   task automatic send_beat(input logic [FUNC_BITS-1:0] f, input logic [WAY_BITS-1:0] w);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= f;
      req_if.way   <= w;
      do @(posedge clock); while (!req_if.ready);
      victims_pending = {victims_pending, predict_victims(f, w)};
      beats_sent++;
   endtask

   // Drop valid, then hold until every expected beat is back and the block settles.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (victims_pending.size() != 0) @(posedge clock);
      repeat (WAYS + 4) @(posedge clock);
   endtask

   task automatic write_ways(input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      ways_setting = value;
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: stall in short random bursts while gaps are on
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            stall = $urandom_range(0, 2);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      victim_pair_type exp_v;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (victims_pending.size() == 0) begin
            report_mismatch("unexpected beat, fifo_victim", 8'd0, 8'(rsp_if.fifo_victim));
         end else begin
            exp_v = victims_pending.pop_front();
            if (rsp_if.fifo_victim !== exp_v.fifo_victim)
               report_mismatch("fifo_victim", 8'(exp_v.fifo_victim), 8'(rsp_if.fifo_victim));
            if (rsp_if.lru_victim !== exp_v.lru_victim)
               report_mismatch("lru_victim", 8'(exp_v.lru_victim), 8'(rsp_if.lru_victim));
         end
         beats_checked++;
      end
   end

   // reset value of ways_in_use, every function, way extremes, ways out of range, clamping
   task automatic test_directed();
      send_beat(FUNC_QUERY, 3'd0);
      send_beat(FUNC_INSERT, 3'd7);
      send_beat(FUNC_USE, 3'd0);
      send_beat(FUNC_BOTH, 3'd3);
      send_beat(FUNC_USE, 3'd7);
      send_beat(FUNC_BOTH, 3'd0);
      send_beat(FUNC_QUERY, 3'd7);
      for (int i = 1; i < 7; i++)
         send_beat(FUNC_INSERT, WAY_BITS'(i));
      wait_idle();
      write_ways(4'd3);
      send_beat(FUNC_BOTH, 3'd5);
      send_beat(FUNC_INSERT, 3'd6);
      send_beat(FUNC_USE, 3'd2);
      send_beat(FUNC_BOTH, 3'd1);
      send_beat(FUNC_QUERY, 3'd0);
      send_beat(FUNC_BOTH, 3'd0);
      send_beat(FUNC_INSERT, 3'd2);
      wait_idle();
      write_ways(4'd15);
      send_beat(FUNC_BOTH, 3'd7);
      send_beat(FUNC_QUERY, 3'd0);
      wait_idle();
      write_ways(4'd0);
      send_beat(FUNC_BOTH, 3'd0);
      send_beat(FUNC_BOTH, 3'd1);
      send_beat(FUNC_QUERY, 3'd3);
   endtask

   // Hammer one way until the others pin at the top age, then release it.
   task automatic test_saturation();
      wait_idle();
      write_ways(4'd2);
      repeat (270) send_beat(FUNC_BOTH, 3'd0);
      send_beat(FUNC_USE, 3'd1);
      send_beat(FUNC_INSERT, 3'd1);
      send_beat(FUNC_QUERY, 3'd0);
      wait_idle();
      write_ways(4'd8);
      for (int i = 0; i < 262; i++)
         send_beat(($urandom_range(0, 15) == 0) ? FUNC_QUERY : FUNC_BOTH, 3'd3);
      send_beat(FUNC_BOTH, 3'd5);
      send_beat(FUNC_QUERY, 3'd2);
   endtask

   // Mostly round-robin fills (which produce FIFO hits) and in-range updates, some noise.
   task automatic test_random(input int phases, input int beats_per_phase);
      logic [CFG_BITS-1:0] settings [10] = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0,
                                             4'd5, 4'd2, 4'd9, 4'd6, 4'd4};
      logic [FUNC_BITS-1:0] f;
      logic [WAY_BITS-1:0]  w;
      logic [WAY_BITS-1:0]  last_way;
      int                   rr_way;
      int                   sel;
      int                   n;
      last_way = '0;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         gaps_on = (p != 6) && (p != phases - 1);
         write_ways((p < 10) ? settings[p] : CFG_BITS'($urandom_range(0, 15)));
         n = live_ways();
         rr_way = 0;
         for (int k = 0; k < beats_per_phase; k++) begin
            sel = $urandom_range(0, 9);
            f = FUNC_BITS'($urandom_range(0, 3));
            if (sel < 4) begin
               f = $urandom_range(0, 1) ? FUNC_INSERT : FUNC_BOTH;
               w = WAY_BITS'(rr_way);
               rr_way = (rr_way + 1) % n;
            end else if (sel < 7) begin
               w = WAY_BITS'($urandom_range(0, n - 1));
            end else if (sel < 9) begin
               w = WAY_BITS'($urandom_range(0, 7));
            end else begin
               w = last_way;
            end
            last_way = w;
            send_beat(f, w);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_if.valid = 1'b0;
      req_if.func  = FUNC_QUERY;
      req_if.way   = '0;
      gaps_on      = 1'b1;
      errors       = 0;
      beats_sent   = 0;
      beats_checked = 0;
      csr_writes   = 0;
      ways_setting = WAYS_IN_USE_RESET;
      for (int i = 0; i < WAYS; i++) begin
         insert_age_q[i] = '0;
         use_age_q[i]    = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_saturation();
      test_random(12, 85);
      wait_idle();

      $display("sent %0d request beats, checked %0d response beats", beats_sent, beats_checked);
      $display("covered %0d ways_in_use writes incl. 0, 1, 8, 15 and age saturation", csr_writes);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout with %0d beats still expected", victims_pending.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ===== age_counter_way_replacement.f =====
hdl/acwr_pkg.sv
hdl/acwr_if.sv
hdl/acwr_age_step.sv
hdl/age_counter_way_replacement.sv
dv/tb_age_counter_way_replacement.sv
